[rtl/mfb_pkg.sv]
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared types and constants of the monochrome frame buffer with panel
// refresh: operation and result codes, panel command bytes, sequencer states.
// ----------------------------------------------------------------------------
package mfb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 160;
  localparam int SCREEN_HEIGHT_DEF = 160;

  localparam logic [2:0] MODE_WR      = 3'd0;
  localparam logic [2:0] MODE_RD      = 3'd1;
  localparam logic [2:0] MODE_HLINE   = 3'd2;
  localparam logic [2:0] MODE_VLINE   = 3'd3;
  localparam logic [2:0] MODE_REFRESH = 3'd4;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CMD    = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;

  localparam logic [7:0] CMD_ADDR0 = 8'h60;
  localparam logic [7:0] CMD_ADDR1 = 8'h70;
  localparam logic [7:0] CMD_ADDR2 = 8'h05;
  localparam logic [7:0] CMD_ADDR3 = 8'h12;
  localparam logic [7:0] NIB_LEFT  = 8'hF0;
  localparam logic [7:0] NIB_RIGHT = 8'h0F;
  localparam logic [7:0] PAD_BYTE  = 8'h00;
  localparam logic [7:0] BIT_MSB   = 8'h80;

  // result slots of one refresh step
  localparam logic [3:0] STEP_CMD0  = 4'd0;
  localparam logic [3:0] STEP_CMD1  = 4'd1;
  localparam logic [3:0] STEP_CMD2  = 4'd2;
  localparam logic [3:0] STEP_CMD3  = 4'd3;
  localparam logic [3:0] STEP_DAT0  = 4'd4;
  localparam logic [3:0] STEP_DAT1  = 4'd5;
  localparam logic [3:0] STEP_DAT2  = 4'd6;
  localparam logic [3:0] STEP_DAT3  = 4'd7;
  localparam logic [3:0] STEP_PAD   = 4'd8;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PIX_RD,
    S_PIX_MOD,
    S_STATUS,
    S_REF_RD,
    S_REF_OUT
  } state_t;

  typedef struct packed {
    logic       on_screen;
    logic [2:0] bit_sel;
  } pix_info_t;

endpackage

[rtl/mfb_ram.sv]
// ----------------------------------------------------------------------------
// mfb_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 3200,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mfb_addr_unit.sv]
// ----------------------------------------------------------------------------
// mfb_addr_unit
// Shared pixel address unit: screen bounds check, byte address of a pixel
// in the packed frame store and its bit position within the byte.
// ----------------------------------------------------------------------------
module mfb_addr_unit import mfb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8,
  parameter int FRAME_BYTES   = ROW_BYTES * SCREEN_HEIGHT,
  parameter int AW            = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
) (
  input  logic [7:0]    px,
  input  logic [7:0]    py,
  output logic [AW-1:0] addr,
  output pix_info_t     info
);

  logic [15:0] lin;

  assign lin = 16'(py) * 16'(ROW_BYTES) + 16'(px[7:3]);
  assign addr = AW'(lin);
  assign info.on_screen = ({1'b0, px} < 9'(SCREEN_WIDTH)) &&
                          ({1'b0, py} < 9'(SCREEN_HEIGHT));
  assign info.bit_sel = px[2:0];

endmodule

[rtl/mfb_ctrl.sv]
// ----------------------------------------------------------------------------
// mfb_ctrl
// Sequencer of the frame buffer: clearing pass, pixel read-modify-write,
// line walks one pixel at a time, and refresh byte streaming.
// ----------------------------------------------------------------------------
module mfb_ctrl import mfb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8,
  parameter int FRAME_BYTES   = ROW_BYTES * SCREEN_HEIGHT,
  parameter int AW            = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1,
  parameter int CW            = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    mode,
  input  logic [7:0]    x,
  input  logic [7:0]    y,
  input  logic [7:0]    line_end,
  input  logic          color,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data,
  output logic          strobe,
  output logic [1:0]    kind,
  output logic [7:0]    bus_byte,
  output logic          ok,
  output logic          pixel_value,
  output logic          last,
  output logic [7:0]    px,
  output logic [7:0]    py,
  input  logic [AW-1:0] pix_addr,
  input  pix_info_t     pix_info,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [7:0]    ram_rdata
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_BYTES - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(ROW_BYTES - 1);

  state_t        state, state_next;
  logic [2:0]    op, op_next;
  logic [7:0]    xr, xr_next;
  logic [7:0]    yr, yr_next;
  logic [7:0]    cur, cur_next;
  logic [7:0]    hi, hi_next;
  logic          colr, colr_next;
  logic          any, any_next;
  logic          pixv, pixv_next;
  logic [3:0]    step, step_next;
  logic          pad, pad_next;
  logic [AW-1:0] scan, scan_next;
  logic [CW-1:0] col, col_next;
  logic          refresh_enable;

  logic          accept;
  logic          is_write;
  logic          walk_done;
  logic          ref_last;
  logic [7:0]    lo_v;
  logic [7:0]    hi_v;
  logic [7:0]    mask;
  logic [1:0]    pair;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign is_write  = (op == MODE_WR) || (op == MODE_HLINE) || (op == MODE_VLINE);
  assign walk_done = (cur == hi);
  assign ref_last  = (step == STEP_PAD) || (step == STEP_DAT3 && !pad);
  assign mask      = BIT_MSB >> pix_info.bit_sel;

  assign px = (op == MODE_VLINE) ? xr : cur;
  assign py = (op == MODE_VLINE) ? cur : yr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      scan           <= '0;
      col            <= '0;
      refresh_enable <= 1'b0;
    end else begin
      state <= state_next;
      scan  <= scan_next;
      col   <= col_next;
      if (cfg_valid && cfg_ready) begin
        refresh_enable <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op   <= op_next;
    xr   <= xr_next;
    yr   <= yr_next;
    cur  <= cur_next;
    hi   <= hi_next;
    colr <= colr_next;
    any  <= any_next;
    pixv <= pixv_next;
    step <= step_next;
    pad  <= pad_next;
  end

  // line ends in order
  always_comb begin
    lo_v = (mode == MODE_VLINE) ? y : x;
    hi_v = line_end;
    if (mode == MODE_WR || mode == MODE_RD) begin
      hi_v = x;
    end else if (lo_v > line_end) begin
      lo_v = line_end;
      hi_v = (mode == MODE_VLINE) ? y : x;
    end
  end

  // datapath registers
  always_comb begin
    op_next   = op;
    xr_next   = xr;
    yr_next   = yr;
    cur_next  = cur;
    hi_next   = hi;
    colr_next = colr;
    any_next  = any;
    pixv_next = pixv;
    step_next = step;
    pad_next  = pad;
    scan_next = scan;
    col_next  = col;
    case (state)
      S_CLEAR: begin
        scan_next = (scan == LAST_ADDR) ? '0 : scan + AW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          op_next   = mode;
          xr_next   = x;
          yr_next   = y;
          cur_next  = lo_v;
          hi_next   = hi_v;
          colr_next = color;
          any_next  = 1'b0;
          pixv_next = 1'b0;
          pad_next  = (scan != '0) && (col == LAST_COL);
          step_next = (scan == '0) ? STEP_CMD0 : STEP_DAT0;
        end
      end
      S_PIX_RD: begin
        if (!pix_info.on_screen && !walk_done) begin
          cur_next = cur + 8'd1;
        end
      end
      S_PIX_MOD: begin
        any_next = 1'b1;
        if (op == MODE_RD) begin
          pixv_next = ram_rdata[3'd7 - pix_info.bit_sel];
        end
        if (!walk_done) begin
          cur_next = cur + 8'd1;
        end
      end
      S_REF_OUT: begin
        if (ref_last) begin
          if (scan == LAST_ADDR) begin
            scan_next = '0;
            col_next  = '0;
          end else begin
            scan_next = scan + AW'(1);
            col_next  = (col == LAST_COL) ? '0 : col + CW'(1);
          end
        end else begin
          step_next = step + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (scan == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_WR, MODE_RD, MODE_HLINE, MODE_VLINE: state_next = S_PIX_RD;
            MODE_REFRESH: state_next = refresh_enable ? S_REF_RD : S_IDLE;
            default: state_next = S_STATUS;
          endcase
        end
      end
      S_PIX_RD: begin
        if (pix_info.on_screen) begin
          state_next = S_PIX_MOD;
        end else if (walk_done) begin
          state_next = S_STATUS;
        end
      end
      S_PIX_MOD: begin
        state_next = walk_done ? S_STATUS : S_PIX_RD;
      end
      S_STATUS: begin
        state_next = S_IDLE;
      end
      S_REF_RD: begin
        state_next = S_REF_OUT;
      end
      S_REF_OUT: begin
        if (ref_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs and memory control
  always_comb begin
    busy        = (state != S_IDLE);
    strobe      = 1'b0;
    kind        = KIND_STATUS;
    bus_byte    = 8'h00;
    ok          = 1'b0;
    pixel_value = 1'b0;
    last        = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = pix_addr;
    ram_wdata   = colr ? (ram_rdata | mask) : (ram_rdata & ~mask);
    ram_re      = 1'b0;
    ram_raddr   = pix_addr;
    pair        = 2'b00;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = scan;
        ram_wdata = 8'h00;
      end
      S_PIX_RD: begin
        ram_re = pix_info.on_screen;
      end
      S_PIX_MOD: begin
        ram_we = is_write;
      end
      S_STATUS: begin
        strobe      = 1'b1;
        ok          = any;
        pixel_value = pixv;
        last        = 1'b1;
      end
      S_REF_RD: begin
        ram_re    = 1'b1;
        ram_raddr = scan;
      end
      S_REF_OUT: begin
        strobe = 1'b1;
        last   = ref_last;
        kind   = KIND_DATA;
        case (step)
          STEP_CMD0: begin
            kind     = KIND_CMD;
            bus_byte = CMD_ADDR0;
          end
          STEP_CMD1: begin
            kind     = KIND_CMD;
            bus_byte = CMD_ADDR1;
          end
          STEP_CMD2: begin
            kind     = KIND_CMD;
            bus_byte = CMD_ADDR2;
          end
          STEP_CMD3: begin
            kind     = KIND_CMD;
            bus_byte = CMD_ADDR3;
          end
          STEP_DAT0: pair = ram_rdata[7:6];
          STEP_DAT1: pair = ram_rdata[5:4];
          STEP_DAT2: pair = ram_rdata[3:2];
          STEP_DAT3: pair = ram_rdata[1:0];
          default:   bus_byte = PAD_BYTE;
        endcase
        if (step inside {[STEP_DAT0:STEP_DAT3]}) begin
          bus_byte = (pair[1] ? NIB_LEFT : 8'h00) | (pair[0] ? NIB_RIGHT : 8'h00);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/mono_framebuffer_lcd_refresh.sv]
// ----------------------------------------------------------------------------
// mono_framebuffer_lcd_refresh
// Monochrome 1 bpp frame buffer with pixel, line and panel refresh operations.
// ----------------------------------------------------------------------------
// After reset the frame store is cleared one byte per cycle, all FRAME_BYTES
// bytes (3200 at 160 by 160), with busy high. An operation is taken when
// start is high and busy low; results appear one per cycle on strobe and
// cannot be held off. Every pixel goes through the one shared address unit,
// and each pixel on screen through a read of the frame RAM, followed by a
// write for pixel writes and lines; a line walks its pixels one at a time,
// then gives the status beat. A refresh step reads one byte of the frame
// RAM and then gives 4 to 8 beats, one per result (a disabled refresh step
// gives no result). Configuration may be written at any time the block is
// idle.
module mono_framebuffer_lcd_refresh import mfb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] mode,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic [7:0] line_end,
  input  logic       color,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  output logic       strobe,
  output logic [1:0] kind,
  output logic [7:0] bus_byte,
  output logic       ok,
  output logic       pixel_value,
  output logic       last
);

  localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
  localparam int FRAME_BYTES = ROW_BYTES * SCREEN_HEIGHT;
  localparam int AW          = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  logic [7:0]    px;
  logic [7:0]    py;
  logic [AW-1:0] pix_addr;
  pix_info_t     pix_info;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  mfb_ctrl #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .x           (x),
    .y           (y),
    .line_end    (line_end),
    .color       (color),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .kind        (kind),
    .bus_byte    (bus_byte),
    .ok          (ok),
    .pixel_value (pixel_value),
    .last        (last),
    .px          (px),
    .py          (py),
    .pix_addr    (pix_addr),
    .pix_info    (pix_info),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  mfb_addr_unit #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_addr (
    .px   (px),
    .py   (py),
    .addr (pix_addr),
    .info (pix_info)
  );

  mfb_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[rtl/mfb_checker.sv]
// ----------------------------------------------------------------------------
// mfb_checker
// Port-level checks of the frame buffer result stream, bound to the top.
// ----------------------------------------------------------------------------
module mfb_checker import mfb_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic [1:0] kind,
  input logic       ok,
  input logic       pixel_value,
  input logic       last
);

  // results only while an operation is in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result beat while idle");

  // the final beat ends the operation
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("result beat after last");

  // a status result is always the last one
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind == KIND_STATUS) |-> last)
    else $error("status beat without last");

  // bus beats carry no status
  a_bus_clean: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind != KIND_STATUS) |-> (!ok && !pixel_value))
    else $error("bus beat with status bits");

  // no result beat in the cycle of an accepted start
  a_accept_gap: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> !strobe)
    else $error("result beat at accept");

endmodule

bind mono_framebuffer_lcd_refresh mfb_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .strobe      (strobe),
  .kind        (kind),
  .ok          (ok),
  .pixel_value (pixel_value),
  .last        (last)
);
